// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the mipmap downsampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge outside of reset.
`define MBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define MBD_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// File: sv/mbd_pkg.sv
// Shared types and constants of the mipmap box downsampler.
package mbd_pkg;

  localparam int CH_W      = 8;
  localparam int SUM_W     = CH_W + 1;
  localparam int NUM_CH    = 3;
  localparam int PIX_W     = NUM_CH * CH_W;
  localparam int LINE_W    = NUM_CH * SUM_W;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 13'd256;

  // Position flags of one pixel as it moves from the input stage to the averaging stage.
  typedef struct packed {
    logic odd_col;
    logic odd_row;
    logic last_col;
    logic last_row;
    logic emit;
  } ctl_t;

endpackage

// File: sv/mbd_line_store.sv
// Line store of horizontal pair sums, one port, registered read data.
module mbd_line_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 27
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/mbd_lane.sv
// One color channel: horizontal pair sum, then the 2x2 floor average.
module mbd_lane (
  input  logic                      clk,
  input  logic                      load,
  input  logic [mbd_pkg::CH_W-1:0]  pix,
  input  logic [mbd_pkg::CH_W-1:0]  held,
  input  logic                      odd_col,
  input  logic [mbd_pkg::SUM_W-1:0] line_sum,
  input  mbd_pkg::ctl_t             ctl,
  output logic [mbd_pkg::SUM_W-1:0] sum_nxt,
  output logic [mbd_pkg::CH_W-1:0]  avg
);
  import mbd_pkg::*;

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W:0]   total;

  // A pair on an odd column adds the held left pixel; a lone pixel stands alone.
  assign sum_nxt = odd_col ? ({1'b0, held} + {1'b0, pix}) : {1'b0, pix};

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r <= sum_nxt;
    end
  end

  assign total = {1'b0, line_sum} + {1'b0, sum_r};

  always_comb begin
    if (ctl.odd_row) begin
      avg = ctl.odd_col ? total[SUM_W:2] : total[SUM_W-1:1];
    end else begin
      avg = ctl.odd_col ? sum_r[SUM_W-1:1] : sum_r[CH_W-1:0];
    end
  end

endmodule

// File: sv/mipmap_box_downsample.sv
// Top level of the mipmap 2x2 box downsampler with its channel lanes and line store.
// The block takes one RGB source pixel per word in raster order and emits the next mipmap level,
// ceil(width/2) by ceil(height/2) pixels, each channel the floor average of its 2x2 source block
// (the vertical pair at an odd last column, the horizontal pair at an odd last row, the pixel
// itself at an odd corner). It accepts one source pixel every clock cycle unless the input stage
// and output register are full and the receiver holds off. A result word goes through the input
// stage, which forms the horizontal pair sums and reads or writes the single-port line store, then
// the averaging stage, whose result lands in the output register. Upper rows of each pair produce
// no output word. Writing src_width or src_height restarts the layer at source pixel (0,0); sizes
// of zero are taken as one and sizes above the maximum as the maximum. The line store needs no
// clearing after reset, since every entry read in a lower row was written in the row above it.
module mipmap_box_downsample #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Source pixels: in_tdata = pixel_red [7:0], pixel_green [15:8], pixel_blue [23:16].
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mbd_pkg::PIX_W-1:0]     in_tdata,
  // Result pixels: out_tdata = out_red [7:0], out_green [15:8], out_blue [23:16].
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mbd_pkg::PIX_W-1:0]     out_tdata,
  // out_tuser = row_end [0]; out_tlast carries layer_end.
  output logic                          out_tuser,
  output logic                          out_tlast,
  // Configuration writes.
  input  logic                          cfg_wr_en,
  input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbd_pkg::CFG_W-1:0]     cfg_wdata
);
  import mbd_pkg::*;

  localparam int CNT_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RCNT_W     = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int W_RST_LAST = ((MAX_WIDTH < 256) ? MAX_WIDTH : 256) - 1;
  localparam int H_RST_LAST = ((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256) - 1;

  // Last usable index for a configured size: zero means one, oversize means the maximum.
  function automatic int size_last(input logic [CFG_W-1:0] v, input int maxv);
    int vi;
    vi = int'(v);
    if (vi == 0) begin
      return 0;
    end
    if (vi > maxv) begin
      return maxv - 1;
    end
    return vi - 1;
  endfunction

  logic [CNT_W-1:0]  width_last_r, width_last_nxt;
  logic [RCNT_W-1:0] height_last_r, height_last_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [RCNT_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0]  held_r;

  logic              in_accept;
  logic              s1_adv;
  logic              s1_valid_r, s1_valid_nxt;
  ctl_t              s1_ctl_r;
  ctl_t              ctl_in;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_data_r;
  logic              out_row_end_r;
  logic              out_layer_end_r;

  logic              ls_we;
  logic              ls_re;
  logic [LINE_AW-1:0] ls_addr;
  logic [LINE_W-1:0] ls_wdata;
  logic [LINE_W-1:0] ls_rdata;
  logic [PIX_W-1:0]  lane_avg;

  // The averaging stage moves on whenever the output register is free or being emptied,
  // so a finished result waiting downstream never holds back a pixel that has room.
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  // Position of the pixel now at the input.
  always_comb begin
    ctl_in.odd_col  = col_r[0];
    ctl_in.odd_row  = row_r[0];
    ctl_in.last_col = (col_r >= width_last_r);
    ctl_in.last_row = (row_r >= height_last_r);
    ctl_in.emit     = (ctl_in.odd_col || ctl_in.last_col) &&
                      (ctl_in.odd_row || ctl_in.last_row);
  end

  // Upper rows of a pair store their pair sums; lower rows fetch them. Both happen in the
  // input stage, so a sum written for one row is always in place when the next row reads it.
  assign ls_addr = LINE_AW'(col_r >> 1);
  assign ls_we   = in_accept && (ctl_in.odd_col || ctl_in.last_col) &&
                   !ctl_in.odd_row && !ctl_in.last_row;
  assign ls_re   = in_accept && ctl_in.odd_row;

  mbd_line_store #(
    .DEPTH (LINE_DEPTH),
    .AW    (LINE_AW),
    .DW    (LINE_W)
  ) u_line (
    .clk   (clk),
    .we    (ls_we),
    .re    (ls_re),
    .addr  (ls_addr),
    .wdata (ls_wdata),
    .rdata (ls_rdata)
  );

  // Three channel lanes work side by side; red is lane zero.
  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    mbd_lane u_lane (
      .clk      (clk),
      .load     (in_accept),
      .pix      (in_tdata[c*CH_W +: CH_W]),
      .held     (held_r[c*CH_W +: CH_W]),
      .odd_col  (ctl_in.odd_col),
      .line_sum (ls_rdata[c*SUM_W +: SUM_W]),
      .ctl      (s1_ctl_r),
      .sum_nxt  (ls_wdata[c*SUM_W +: SUM_W]),
      .avg      (lane_avg[c*CH_W +: CH_W])
    );
  end

  // Raster counters and size registers; any size write restarts the layer.
  always_comb begin
    width_last_nxt  = width_last_r;
    height_last_nxt = height_last_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    if (in_accept) begin
      if (ctl_in.last_col) begin
        col_nxt = '0;
        row_nxt = ctl_in.last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (cfg_wr_en) begin
      col_nxt = '0;
      row_nxt = '0;
      case (cfg_index)
        REG_SRC_WIDTH: begin
          width_last_nxt = CNT_W'(size_last(cfg_wdata, MAX_WIDTH));
        end
        REG_SRC_HEIGHT: begin
          height_last_nxt = RCNT_W'(size_last(cfg_wdata, MAX_HEIGHT));
        end
        default: begin
        end
      endcase
    end
  end

  assign s1_valid_nxt = in_tready ? in_accept : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_last_r  <= CNT_W'(W_RST_LAST);
      height_last_r <= RCNT_W'(H_RST_LAST);
      col_r         <= '0;
      row_r         <= '0;
      held_r        <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      width_last_r  <= width_last_nxt;
      height_last_r <= height_last_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      s1_valid_r    <= s1_valid_nxt;
      if (in_accept && !ctl_in.odd_col) begin
        held_r <= in_tdata;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r && s1_ctl_r.emit;
      end
    end
  end

  // Payload of the two later stages.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ctl_r <= ctl_in;
    end
    if (s1_adv && s1_valid_r && s1_ctl_r.emit) begin
      out_data_r      <= lane_avg;
      out_row_end_r   <= s1_ctl_r.last_col;
      out_layer_end_r <= s1_ctl_r.last_col && s1_ctl_r.last_row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_row_end_r;
  assign out_tlast  = out_layer_end_r;

`include "assert_macros.svh"

  `MBD_ASSERT(a_line_one_port, !(ls_we && ls_re), "line store read and written together")
  `MBD_ASSERT(a_stall_cause, !in_tready |-> (s1_valid_r && out_valid_r), "input stalled with room")
  `MBD_ASSERT_NEXT(a_layer_wrap, in_accept && ctl_in.last_col && ctl_in.last_row, (col_r == '0) && (row_r == '0), "counters did not wrap at layer end")

endmodule

// File: test/mipmap_box_downsample_tb.sv
// Self-checking testbench of the mipmap 2x2 box downsampler with a built-in pixel predictor.
`timescale 1ns / 100ps

module mipmap_box_downsample_tb;

  import mbd_pkg::*;

  // The block under test keeps its default maximum sizes.
  localparam int MAX_SIZE   = 4096;
  localparam int LINE_DEPTH = (MAX_SIZE + 1) / 2;

  // Random source words after the directed part.
  localparam int RANDOM_ITEMS = 760;

  // The pipeline is two stages deep, so a pixel that causes no result word can still be in
  // flight after the last result has left. The settling wait covers it with margin.
  localparam int SETTLE_CYCLES = 8;

  // Receiver hold-off that backs the block up all the way to its input.
  localparam int LONG_HOLD = 500;

  // The slowest correct run is about 1,450 source words. Each may wait for a sender gap and,
  // when every word causes a result, for a receiver that seldom takes a word. With the long
  // hold-off and the settling after each layer, that run stays far inside this limit.
  localparam int CYCLE_LIMIT = 200000;

  // Random phases that carry the long receiver hold-off and the mid-layer sender pause.
  localparam int HOLD_PHASE  = 0;
  localparam int PAUSE_PHASE = 1;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pix_t;

  // Horizontal pair sums of one upper-row pair, one 9-bit sum per channel.
  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } pair_sum_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            row_end;
    logic            layer_end;
  } mip_pixel_t;

  typedef enum int {PIX_MIXED, PIX_EXTREME, PIX_MAX} pix_style_e;
  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_ALTERNATE} rx_mode_e;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [PIX_W-1:0] in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [PIX_W-1:0] out_tdata;
  logic             out_tuser;
  logic             out_tlast;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  mipmap_box_downsample #(
    .MAX_WIDTH (MAX_SIZE),
    .MAX_HEIGHT(MAX_SIZE)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Source pixels waiting for the driver, and result words the predictor has worked out.
  pix_t       pending_pixels[$];
  mip_pixel_t expected_pixels[$];

  int pushed_count   = 0;
  int offered_count  = 0;
  int accepted_count = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int hold_request   = 0;

  // Predictor state: its own copy of the size registers, the position of the next source
  // pixel, the even-column pixel of the current pair and the upper-row pair sums.
  logic [CFG_W-1:0] layer_width;
  logic [CFG_W-1:0] layer_height;
  int unsigned      cur_col;
  int unsigned      cur_row;
  pix_t             left_pixel;
  pair_sum_t        upper_sums[LINE_DEPTH];

  // Works out the result word, if any, that one accepted source pixel causes.
  task automatic downsample_pixel(input pix_t px);
    int unsigned w, h, idx;
    logic        last_col, last_row, odd_col, odd_row;
    int unsigned pix_c[3], left_c[3], line_c[3], sum_c[3], avg_c[3];
    mip_pixel_t  res;
    w = (layer_width == 0) ? 1 : ((layer_width > MAX_SIZE) ? MAX_SIZE : layer_width);
    h = (layer_height == 0) ? 1 : ((layer_height > MAX_SIZE) ? MAX_SIZE : layer_height);
    idx = cur_col >> 1;
    last_col = (cur_col + 1 >= w);
    last_row = (cur_row + 1 >= h);
    odd_col = cur_col[0];
    odd_row = cur_row[0];
    pix_c  = '{px.red, px.green, px.blue};
    left_c = '{left_pixel.red, left_pixel.green, left_pixel.blue};
    line_c = '{upper_sums[idx].red, upper_sums[idx].green, upper_sums[idx].blue};
    for (int c = 0; c < 3; c++) begin
      // A lone pixel at an odd last column stands in for its pair.
      sum_c[c] = odd_col ? left_c[c] + pix_c[c] : pix_c[c];
    end
    if (!odd_col) begin
      left_pixel = px;
    end
    if (odd_col || last_col) begin
      if (odd_row) begin
        // Lower row: full 2x2 block, or the vertical pair at an odd last column.
        for (int c = 0; c < 3; c++) begin
          avg_c[c] = odd_col ? (line_c[c] + sum_c[c]) >> 2 : (line_c[c] + sum_c[c]) >> 1;
        end
      end else if (last_row) begin
        // Odd last row: horizontal pair, or the corner pixel copied as it is.
        for (int c = 0; c < 3; c++) begin
          avg_c[c] = odd_col ? sum_c[c] >> 1 : sum_c[c];
        end
      end else begin
        upper_sums[idx] = '{red: SUM_W'(sum_c[0]), green: SUM_W'(sum_c[1]),
                            blue: SUM_W'(sum_c[2])};
      end
      if (odd_row || last_row) begin
        res.red       = CH_W'(avg_c[0]);
        res.green     = CH_W'(avg_c[1]);
        res.blue      = CH_W'(avg_c[2]);
        res.row_end   = last_col;
        res.layer_end = last_col && last_row;
        expected_pixels.push_back(res);
      end
    end
    if (last_col) begin
      cur_col = 0;
      cur_row = last_row ? 0 : cur_row + 1;
    end else begin
      cur_col = cur_col + 1;
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Everything that happens at the rising edge: reset and register writes of the predictor,
  // checking of each result word against the oldest expectation, and prediction for each
  // source word the block takes. Result words come from registers fed by earlier source words,
  // so checking before predicting never needs an expectation from the same edge.
  always @(posedge clk) begin : observe
    mip_pixel_t want;
    pix_t       got;
    if (!rst_n) begin
      layer_width  = SIZE_RESET;
      layer_height = SIZE_RESET;
      cur_col      = 0;
      cur_row      = 0;
      left_pixel   = '0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_SRC_WIDTH) begin
          layer_width = cfg_wdata;
        end else begin
          layer_height = cfg_wdata;
        end
        // Either write restarts the layer at source pixel (0,0).
        cur_col = 0;
        cur_row = 0;
      end
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("result word arrived with no expectation waiting");
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          got  = out_tdata;
          check_field("out_red", want.red, got.red);
          check_field("out_green", want.green, got.green);
          check_field("out_blue", want.blue, got.blue);
          check_field("row_end", want.row_end, out_tuser);
          check_field("layer_end", want.layer_end, out_tlast);
        end
      end
      if (in_tvalid && in_tready) begin
        accepted_count++;
        downsample_pixel(in_tdata);
      end
    end
  end

  // Sender: bursts of random length with random gaps between them. A word on the bus stays
  // there until the rising edge that takes it.
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && accepted_count != offered_count) begin
      // The current word has not been taken yet; hold it.
    end else if (gap_left > 0) begin
      in_tvalid <= 1'b0;
      gap_left--;
    end else if (pending_pixels.size() > 0) begin
      in_tdata  <= pending_pixels.pop_front();
      in_tvalid <= 1'b1;
      offered_count++;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 48);
        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
      end else begin
        burst_left--;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: it switches between random stall patterns. On request it holds off for a long
  // stretch so that the block fills up and stops taking source words.
  int       rx_cycle    = 0;
  int       hold_left   = 0;
  int       hold_served = 0;
  rx_mode_e rx_mode     = RX_ALWAYS;

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 128 == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_served != hold_request) begin
      hold_served = hold_request;
      hold_left   = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:    out_tready <= 1'b1;
        RX_MOSTLY:    out_tready <= ($urandom_range(0, 3) != 0);
        RX_RARELY:    out_tready <= ($urandom_range(0, 3) == 0);
        RX_ALTERNATE: out_tready <= rx_cycle[0];
        default:      out_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Queues source words. Mixed pixels are mostly uniform random, sometimes built from
  // channel extremes so that saturating sums turn up often.
  task automatic push_pixels(input int count, input pix_style_e style);
    pix_t p;
    for (int i = 0; i < count; i++) begin
      if (style == PIX_MAX) begin
        p = '1;
      end else if (style == PIX_EXTREME || $urandom_range(0, 19) < 3) begin
        p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        p = PIX_W'($urandom);
      end
      pending_pixels.push_back(p);
      pushed_count++;
    end
  endtask

  // Waits until every queued word has been taken and every expected result has arrived,
  // then lets the pipeline settle before the registers may change.
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || accepted_count != pushed_count ||
           expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int plan_w, plan_h, pick, which, layer, count, random_items, phase;
    plan_w = SIZE_RESET;
    plan_h = SIZE_RESET;
    random_items = 0;
    phase = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset sizes of 256 by 256: two full rows and a few pixels of the next pair.
    push_pixels(2 * 256 + 4, PIX_MIXED);
    wait_idle();

    // Directed part. A 3x3 layer covers the full block, the odd last column, the odd last
    // row and the odd corner, all with channel extremes.
    write_reg(REG_SRC_WIDTH, 13'd3);
    write_reg(REG_SRC_HEIGHT, 13'd3);
    push_pixels(9, PIX_EXTREME);
    wait_idle();
    // Sizes of zero act as one: every pixel is a whole layer and copies through.
    write_reg(REG_SRC_WIDTH, 13'd0);
    write_reg(REG_SRC_HEIGHT, 13'd0);
    push_pixels(2, PIX_MIXED);
    wait_idle();
    // All channels at full scale in a 2x2 block: the largest sums there are.
    write_reg(REG_SRC_WIDTH, 13'd2);
    write_reg(REG_SRC_HEIGHT, 13'd2);
    push_pixels(4, PIX_MAX);
    wait_idle();
    // Rewriting one register alone still restarts the layer.
    write_reg(REG_SRC_WIDTH, 13'd3);
    push_pixels(6, PIX_MIXED);
    wait_idle();
    plan_w = 3;
    plan_h = 2;

    // Random layers, mostly small, often several back to back so that the counters wrap,
    // and often cut short by the next register write.
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      which = $urandom_range(0, 9);
      if (pick < 14) begin
        if (which != 1) plan_w = $urandom_range(1, 12);
        if (which != 0) plan_h = $urandom_range(1, 10);
      end else if (pick < 19) begin
        if (which != 1) plan_w = $urandom_range(13, 80);
        if (which != 0) plan_h = $urandom_range(1, 4);
      end else begin
        if (which != 1) plan_w = $urandom_range(1, 3);
        if (which != 0) plan_h = $urandom_range(20, 60);
      end
      if (phase == HOLD_PHASE) begin
        plan_w = 6;
        plan_h = 8;
        which  = 2;
      end
      if (which != 1) begin
        write_reg(REG_SRC_WIDTH, (plan_w == 1 && $urandom_range(0, 1)) ? 13'd0 : CFG_W'(plan_w));
      end
      if (which != 0) begin
        write_reg(REG_SRC_HEIGHT, (plan_h == 1 && $urandom_range(0, 1)) ? 13'd0 : CFG_W'(plan_h));
      end
      layer = plan_w * plan_h;
      count = layer * $urandom_range(1, 2);
      if ($urandom_range(0, 1)) begin
        count += $urandom_range(1, layer);
      end
      if (phase == HOLD_PHASE) begin
        count = 3 * layer;
        hold_request++;
      end
      // The last layer is cut short so the random part stays near its budget.
      if (count > RANDOM_ITEMS - random_items) begin
        count = RANDOM_ITEMS - random_items;
      end
      if (phase == PAUSE_PHASE) begin
        // The sender stops in mid-layer until every expected word is out, then goes on.
        push_pixels(count / 2, PIX_MIXED);
        wait_idle();
        push_pixels(count - count / 2, PIX_MIXED);
      end else begin
        push_pixels(count, PIX_MIXED);
      end
      wait_idle();
      random_items += count;
      phase++;
    end

    // A width above the maximum acts as the maximum: a single-row layer gives horizontal
    // pairs that never close the row.
    write_reg(REG_SRC_WIDTH, 13'd4097);
    write_reg(REG_SRC_HEIGHT, 13'd1);
    push_pixels(64, PIX_MIXED);
    wait_idle();
    // The largest height value acts as the maximum: vertical pairs that never close the layer.
    write_reg(REG_SRC_WIDTH, 13'd1);
    write_reg(REG_SRC_HEIGHT, 13'd8191);
    push_pixels(64, PIX_MIXED);
    wait_idle();

    if (expected_pixels.size() != 0) begin
      $error("%0d expected result words never arrived", expected_pixels.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/mbd_pkg.sv
sv/mbd_line_store.sv
sv/mbd_lane.sv
sv/mipmap_box_downsample.sv
test/mipmap_box_downsample_tb.sv
